// ----- design/netpbm_pixel_payload_decoder_core_macros.svh -----
// Assertion helpers shared by the decoder RTL.
`ifndef NETPBM_PIXEL_PAYLOAD_DECODER_CORE_MACROS_SVH
`define NETPBM_PIXEL_PAYLOAD_DECODER_CORE_MACROS_SVH

// Same-cycle implication.
`define NPD_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("npd check failed");

// Next-cycle implication.
`define NPD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("npd check failed");

`endif

// ----- design/npd_pkg.sv -----
`timescale 1ns / 1ps

package npd_pkg;

    localparam int MAX_DIM   = 4096;
    localparam int CNT_W     = $clog2(MAX_DIM);
    localparam int DIM_W     = 13;
    localparam int GRAY_W    = 8;
    localparam int BYTE_W    = 8;
    localparam int DIV_W     = 2 * GRAY_W;
    localparam int DIV_CNT_W = $clog2(DIV_W);
    localparam int BIT_CNT_W = $clog2(BYTE_W);
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 13;

    localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [BYTE_W-1:0] CHAR_NINE  = 8'h39;
    localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CHAR_TAB   = 8'h09;
    localparam logic [BYTE_W-1:0] CHAR_CR    = 8'h0D;
    localparam logic [GRAY_W-1:0] GRAY_WHITE = 8'hFF;
    localparam logic [GRAY_W-1:0] GRAY_BLACK = 8'h00;

    typedef enum logic [1:0] {
        MODE_ASCII_BIT  = 2'd0,
        MODE_ASCII_GRAY = 2'd1,
        MODE_PACKED_BIT = 2'd2,
        MODE_RAW_GRAY   = 2'd3
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE     = 2'd0,
        CFG_WIDTH    = 2'd1,
        CFG_HEIGHT   = 2'd2,
        CFG_GRAY_MAX = 2'd3
    } cfg_idx_t;

    typedef enum logic [1:0] {
        K_ASCII_BIT  = 2'd0,
        K_PACKED_BIT = 2'd1,
        K_SCALED     = 2'd2,
        K_ERROR      = 2'd3
    } kind_t;

    typedef struct packed {
        logic  capture;
        logic  acc_digit;
        logic  acc_clear;
        logic  div_start;
        logic  div_use_byte;
        logic  shift_load;
        logic  emit;
        kind_t kind;
    } cmd_t;

    typedef struct packed {
        mode_t mode;
        logic  done;
        logic  is_digit;
        logic  is_space;
        logic  pending;
        logic  fin;
        logic  emit_last;
        logic  out_free;
        logic  div_done;
    } status_t;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        r = v;
        if (v == '0)
            r = DIM_W'(1);
        else if (v > DIM_W'(MAX_DIM))
            r = DIM_W'(MAX_DIM);
        return r;
    endfunction

    function automatic logic is_ws(input logic [BYTE_W-1:0] c);
        return (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
    endfunction

endpackage

// ----- design/npd_div.sv -----
`timescale 1ns / 1ps

// value*255 / divisor, restoring, one quotient bit per cycle
module npd_div
    import npd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [GRAY_W-1:0] value,
    input  logic [GRAY_W-1:0] divisor,
    output logic              done,
    output logic [GRAY_W-1:0] quotient
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [GRAY_W-1:0]    rem_reg, rem_next;
    logic [DIV_W-1:0]     qd_reg, qd_next;
    logic [GRAY_W-1:0]    dvs_reg, dvs_next;
    logic [GRAY_W:0]      rem_sh;
    logic [GRAY_W:0]      rem_sub;
    logic                 ge;

    assign rem_sh  = {rem_reg, qd_reg[DIV_W-1]};
    assign ge      = rem_sh >= {1'b0, dvs_reg};
    assign rem_sub = rem_sh - {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = done_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        qd_next   = qd_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            done_next = 1'b0;
            cnt_next  = '0;
            rem_next  = '0;
            qd_next   = {value, {GRAY_W{1'b0}}} - {{GRAY_W{1'b0}}, value};
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? rem_sub[GRAY_W-1:0] : rem_sh[GRAY_W-1:0];
            qd_next  = {qd_reg[DIV_W-2:0], ge};
            cnt_next = cnt_reg + DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(DIV_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        qd_reg  <= qd_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = qd_reg[GRAY_W-1:0];

endmodule

// ----- design/npd_dp.sv -----
`timescale 1ns / 1ps

module npd_dp
    import npd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [BYTE_W-1:0]    s_tdata,
    input  logic                 s_tlast,
    input  logic                 cfg_valid,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data,
    input  logic                 m_tready,
    input  cmd_t                 cmd,
    output status_t              st,
    output logic                 m_tvalid,
    output logic [GRAY_W-1:0]    m_tdata,
    output logic                 m_tlast,
    output logic [1:0]           m_tuser
);

    mode_t                mode_reg;
    logic [DIM_W-1:0]     width_reg;
    logic [DIM_W-1:0]     height_reg;
    logic [GRAY_W-1:0]    gmax_reg;

    logic [BYTE_W-1:0]    byte_reg;
    logic                 fin_reg;
    logic [GRAY_W-1:0]    acc_reg, acc_next;
    logic                 pend_reg, pend_next;
    logic                 done_reg, done_next;
    logic [CNT_W-1:0]     col_reg, col_next;
    logic [CNT_W-1:0]     row_reg, row_next;
    logic [BYTE_W-1:0]    shift_reg;
    logic [BIT_CNT_W-1:0] bit_reg;

    logic                 ovalid_reg, ovalid_next;
    logic [GRAY_W-1:0]    ogray_reg;
    logic                 olast_reg;
    logic                 ocomp_reg;
    logic                 oerr_reg;

    logic [DIM_W-1:0]     w_cl;
    logic [DIM_W-1:0]     h_cl;
    logic                 row_end;
    logic                 img_end;
    logic                 is_pixel;
    logic                 e_last;
    logic [GRAY_W-1:0]    e_gray;
    logic                 div_done;
    logic [GRAY_W-1:0]    div_q;

    assign w_cl     = clamp_dim(width_reg);
    assign h_cl     = clamp_dim(height_reg);
    assign row_end  = (DIM_W'(col_reg) + DIM_W'(1)) >= w_cl;
    assign img_end  = (DIM_W'(row_reg) + DIM_W'(1)) >= h_cl;
    assign is_pixel = cmd.kind != K_ERROR;
    assign e_last   = (cmd.kind != K_PACKED_BIT) || row_end ||
                      (bit_reg == BIT_CNT_W'(BYTE_W - 1));

    always_comb
    begin
        unique case (cmd.kind)
            K_ASCII_BIT:  e_gray = (byte_reg == CHAR_ZERO) ? GRAY_WHITE : GRAY_BLACK;
            K_PACKED_BIT: e_gray = shift_reg[BYTE_W-1] ? GRAY_BLACK : GRAY_WHITE;
            K_SCALED:     e_gray = div_q;
            K_ERROR:      e_gray = GRAY_BLACK;
        endcase
    end

    npd_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .value    (cmd.div_use_byte ? byte_reg : acc_reg),
        .divisor  (gmax_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    always_comb
    begin
        acc_next    = acc_reg;
        pend_next   = pend_reg;
        done_next   = done_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        ovalid_next = ovalid_reg;
        if (cmd.acc_digit)
        begin
            acc_next  = (acc_reg << 3) + (acc_reg << 1) + (byte_reg - CHAR_ZERO);
            pend_next = 1'b1;
        end
        if (cmd.acc_clear)
        begin
            acc_next  = '0;
            pend_next = 1'b0;
        end
        if (m_tready)
            ovalid_next = 1'b0;
        if (cmd.emit)
        begin
            ovalid_next = 1'b1;
            if (is_pixel)
            begin
                if (row_end)
                begin
                    col_next = '0;
                    if (img_end)
                        done_next = 1'b1;
                    else
                        row_next = row_reg + CNT_W'(1);
                end
                else
                begin
                    col_next = col_reg + CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_ASCII_BIT;
            width_reg  <= DIM_W'(1);
            height_reg <= DIM_W'(1);
            gmax_reg   <= GRAY_WHITE;
            acc_reg    <= '0;
            pend_reg   <= 1'b0;
            done_reg   <= 1'b0;
            col_reg    <= '0;
            row_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_idx_t'(cfg_index))
                    CFG_MODE:     mode_reg   <= mode_t'(cfg_data[1:0]);
                    CFG_WIDTH:    width_reg  <= cfg_data[DIM_W-1:0];
                    CFG_HEIGHT:   height_reg <= cfg_data[DIM_W-1:0];
                    CFG_GRAY_MAX: gmax_reg   <= cfg_data[GRAY_W-1:0];
                endcase
            end
            acc_reg    <= acc_next;
            pend_reg   <= pend_next;
            done_reg   <= done_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            byte_reg <= s_tdata;
            fin_reg  <= s_tlast;
        end
        if (cmd.shift_load)
        begin
            shift_reg <= byte_reg;
            bit_reg   <= '0;
        end
        else if (cmd.emit && (cmd.kind == K_PACKED_BIT))
        begin
            shift_reg <= {shift_reg[BYTE_W-2:0], 1'b0};
            bit_reg   <= bit_reg + BIT_CNT_W'(1);
        end
        if (cmd.emit)
        begin
            ogray_reg <= e_gray;
            olast_reg <= e_last;
            ocomp_reg <= is_pixel && row_end && img_end;
            oerr_reg  <= !is_pixel;
        end
    end

    assign st.mode      = mode_reg;
    assign st.done      = done_reg;
    assign st.is_digit  = (byte_reg >= CHAR_ZERO) && (byte_reg <= CHAR_NINE);
    assign st.is_space  = is_ws(byte_reg);
    assign st.pending   = pend_reg;
    assign st.fin       = fin_reg;
    assign st.emit_last = e_last;
    assign st.out_free  = !ovalid_reg || m_tready;
    assign st.div_done  = div_done;

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = ogray_reg;
    assign m_tlast  = olast_reg;
    assign m_tuser  = {oerr_reg, ocomp_reg};

endmodule

// ----- design/npd_ctrl.sv -----
`timescale 1ns / 1ps

module npd_ctrl
    import npd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    s_tvalid,
    output logic    s_tready,
    input  status_t st,
    output cmd_t    cmd
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_DECODE = 5'b00010,
        S_FLUSH  = 5'b00100,
        S_DIV    = 5'b01000,
        S_EMIT   = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    kind_t  kind_reg, kind_next;

    always_comb
    begin
        state_next       = state_reg;
        kind_next        = kind_reg;
        cmd.capture      = 1'b0;
        cmd.acc_digit    = 1'b0;
        cmd.acc_clear    = 1'b0;
        cmd.div_start    = 1'b0;
        cmd.div_use_byte = 1'b0;
        cmd.shift_load   = 1'b0;
        cmd.emit         = 1'b0;
        cmd.kind         = kind_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE:
            begin
                state_next = S_IDLE;
                if (!st.done)
                begin
                    unique case (st.mode)
                        MODE_ASCII_BIT:
                        begin
                            if (!st.is_space)
                            begin
                                kind_next  = K_ASCII_BIT;
                                state_next = S_EMIT;
                            end
                        end
                        MODE_ASCII_GRAY:
                        begin
                            if (st.is_digit)
                            begin
                                cmd.acc_digit = 1'b1;
                                if (st.fin)
                                    state_next = S_FLUSH;
                            end
                            else if (st.is_space)
                            begin
                                if (st.pending)
                                begin
                                    cmd.div_start = 1'b1;
                                    cmd.acc_clear = 1'b1;
                                    kind_next     = K_SCALED;
                                    state_next    = S_DIV;
                                end
                            end
                            else
                            begin
                                cmd.acc_clear = 1'b1;
                                kind_next     = K_ERROR;
                                state_next    = S_EMIT;
                            end
                        end
                        MODE_PACKED_BIT:
                        begin
                            cmd.shift_load = 1'b1;
                            kind_next      = K_PACKED_BIT;
                            state_next     = S_EMIT;
                        end
                        MODE_RAW_GRAY:
                        begin
                            cmd.div_start    = 1'b1;
                            cmd.div_use_byte = 1'b1;
                            kind_next        = K_SCALED;
                            state_next       = S_DIV;
                        end
                    endcase
                end
            end
            S_FLUSH:
            begin
                cmd.div_start = 1'b1;
                cmd.acc_clear = 1'b1;
                kind_next     = K_SCALED;
                state_next    = S_DIV;
            end
            S_DIV:
            begin
                if (st.div_done)
                    state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (st.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (st.emit_last)
                        state_next = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            kind_reg  <= K_ASCII_BIT;
        end
        else
        begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
        end
    end

    assign s_tready = state_reg == S_IDLE;

endmodule

// ----- design/netpbm_pixel_payload_decoder_core.sv -----
`timescale 1ns / 1ps
// Path: a byte is captured in S_IDLE and decoded in S_DECODE; a bitmap pixel or error
// word is then registered from S_EMIT, while a gray pixel first passes S_DIV (after
// S_FLUSH on a final-byte flush), where the 16-step restoring divider runs.
// Packed bitmap: one pixel per cycle while the output is free; one byte at a time.
// Reset (rst_n, async, active low) clears counters, pending number and config registers.
`include "netpbm_pixel_payload_decoder_core_macros.svh"

module netpbm_pixel_payload_decoder_core
    import npd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,   // [7:0] payload_byte
    input  logic                 s_tlast,   // final_byte
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [7:0]           m_tdata,   // [7:0] gray_value
    output logic                 m_tlast,   // last_of_run
    output logic [1:0]           m_tuser,   // [0] image_complete, [1] syntax_error
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data
);

    cmd_t    cmd;
    status_t st;

    assign cfg_ready = 1'b1;

    npd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    npd_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tready  (m_tready),
        .cmd       (cmd),
        .st        (st),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    `NPD_ASSERT_IMPL(a_err_word_clean, m_tvalid && m_tuser[1], !m_tuser[0] && (m_tdata == '0))
    `NPD_ASSERT_IMPL(a_complete_is_last, m_tvalid && m_tuser[0], m_tlast)
    `NPD_ASSERT_NEXT(a_one_byte_at_a_time, s_tvalid && s_tready, !s_tready)
    `NPD_ASSERT_NEXT(a_nothing_after_complete, m_tvalid && m_tready && m_tuser[0], !m_tvalid)

endmodule

// ----- tb/sv/netpbm_pixel_payload_decoder_core_tb.sv -----
`timescale 1ns / 1ps

module netpbm_pixel_payload_decoder_core_tb;
    import npd_pkg::*;

    localparam int DRAIN_CYCLES = 40;
    localparam int STALL_LIMIT  = 2000;
    localparam int MAX_REPORTS  = 100;
    localparam int RUN_LEN      = 27;

    typedef struct packed {
        logic [7:0] data;
        logic       fin;
    } payload_item_t;

    typedef struct packed {
        logic [7:0] gray;
        logic       last;
        logic       complete;
        logic       syn_err;
    } pixel_word_t;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata   = '0;
    logic                 s_tlast   = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [7:0]           m_tdata;
    logic                 m_tlast;
    logic [1:0]           m_tuser;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DAT_W-1:0] cfg_data  = '0;

    payload_item_t payload_q[$];
    pixel_word_t   expected_pixels[$];
    pixel_word_t   step_results[$];

    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int          mismatch_count = 0;
    int          quiet_cycles   = 0;

    // decoder state mirror
    mode_t       mode_reg   = MODE_ASCII_BIT;
    logic [12:0] width_reg  = 13'd1;
    logic [12:0] height_reg = 13'd1;
    logic [7:0]  gmax_reg   = 8'd255;
    int          col_cnt    = 0;
    int          row_cnt    = 0;
    logic [7:0]  digit_acc  = '0;
    logic        num_pend   = 1'b0;
    logic        img_done   = 1'b0;

    netpbm_pixel_payload_decoder_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int dim_clamp(input logic [12:0] v);
        if (v == 13'd0)
            return 1;
        if (v > 13'(MAX_DIM))
            return MAX_DIM;
        return int'(v);
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CHAR_SPACE) || (c >= CHAR_TAB && c <= CHAR_CR);
    endfunction

    function automatic logic [7:0] scale_to_byte(input logic [7:0] v);
        logic [15:0] q;
        if (gmax_reg == 8'd0)
            return GRAY_WHITE;
        q = (16'(v) * 16'd255) / 16'(gmax_reg);
        return q[7:0];
    endfunction

    task automatic add_pixel(input logic [7:0] g);
        pixel_word_t w;
        w.gray     = g;
        w.last     = 1'b0;
        w.complete = 1'b0;
        w.syn_err  = 1'b0;
        if (col_cnt + 1 >= dim_clamp(width_reg))
        begin
            col_cnt = 0;
            if (row_cnt + 1 >= dim_clamp(height_reg))
            begin
                w.complete = 1'b1;
                img_done   = 1'b1;
            end
            else
                row_cnt++;
        end
        else
            col_cnt++;
        step_results.push_back(w);
    endtask

    task automatic apply_reg(input logic [CFG_IDX_W-1:0] idx, input logic [12:0] val);
        case (cfg_idx_t'(idx))
            CFG_MODE:     mode_reg   = mode_t'(val[1:0]);
            CFG_WIDTH:    width_reg  = val;
            CFG_HEIGHT:   height_reg = val;
            CFG_GRAY_MAX: gmax_reg   = val[7:0];
            default:      ;
        endcase
    endtask

    task automatic decode_payload_byte(input logic [7:0] b, input logic fin);
        pixel_word_t err_word;
        logic        stop;
        logic        at_end;
        int          bit_i;
        step_results.delete();
        if (!img_done)
        begin
            case (mode_reg)
                MODE_ASCII_BIT:
                begin
                    if (!is_blank(b))
                        add_pixel(b == CHAR_ZERO ? GRAY_WHITE : GRAY_BLACK);
                end
                MODE_ASCII_GRAY:
                begin
                    if (b >= CHAR_ZERO && b <= CHAR_NINE)
                    begin
                        digit_acc = 8'(digit_acc * 8'd10 + (b - CHAR_ZERO));
                        num_pend  = 1'b1;
                    end
                    else if (is_blank(b))
                    begin
                        if (num_pend)
                        begin
                            add_pixel(scale_to_byte(digit_acc));
                            digit_acc = '0;
                            num_pend  = 1'b0;
                        end
                    end
                    else
                    begin
                        digit_acc         = '0;
                        num_pend          = 1'b0;
                        err_word.gray     = GRAY_BLACK;
                        err_word.last     = 1'b0;
                        err_word.complete = 1'b0;
                        err_word.syn_err  = 1'b1;
                        step_results.push_back(err_word);
                    end
                    if (fin && num_pend && !img_done)
                    begin
                        add_pixel(scale_to_byte(digit_acc));
                        digit_acc = '0;
                        num_pend  = 1'b0;
                    end
                end
                MODE_PACKED_BIT:
                begin
                    stop = 1'b0;
                    for (bit_i = 7; bit_i >= 0; bit_i--)
                    begin
                        if (!stop && !img_done)
                        begin
                            // bits past the row end are padding
                            at_end = (col_cnt + 1 >= dim_clamp(width_reg));
                            add_pixel(b[bit_i] ? GRAY_BLACK : GRAY_WHITE);
                            stop = at_end;
                        end
                    end
                end
                default:
                    add_pixel(scale_to_byte(b));
            endcase
        end
        if (step_results.size() != 0)
            step_results[step_results.size() - 1].last = 1'b1;
        foreach (step_results[i])
            expected_pixels.push_back(step_results[i]);
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin : drive_proc
        payload_item_t item;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tlast  <= 1'b0;
        end
        else if (!s_tvalid || s_tready)
        begin
            if (payload_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                item = payload_q.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= item.data;
                s_tlast  <= item.fin;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // monitor
    always @(posedge clk)
    begin : monitor_proc
        pixel_word_t got;
        pixel_word_t want;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                apply_reg(cfg_index, cfg_data);
            if (s_tvalid && s_tready)
                decode_payload_byte(s_tdata, s_tlast);
            if (m_tvalid && m_tready)
            begin
                got.gray     = m_tdata;
                got.last     = m_tlast;
                got.complete = m_tuser[0];
                got.syn_err  = m_tuser[1];
                if (expected_pixels.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("%0t: expected no word, got gray=%0d last=%b complete=%b err=%b",
                                 $time, got.gray, got.last, got.complete, got.syn_err);
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    if (got.gray !== want.gray || got.last !== want.last ||
                        got.complete !== want.complete || got.syn_err !== want.syn_err)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS)
                            $display({"%0t: expected gray=%0d last=%b complete=%b err=%b, ",
                                      "got gray=%0d last=%b complete=%b err=%b"},
                                     $time, want.gray, want.last, want.complete, want.syn_err,
                                     got.gray, got.last, got.complete, got.syn_err);
                    end
                end
            end
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    task automatic write_reg(input cfg_idx_t idx, input logic [12:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic configure(input mode_t m, input logic [12:0] w, input logic [12:0] h,
                             input logic [7:0] g);
        write_reg(CFG_MODE, 13'(m));
        write_reg(CFG_WIDTH, w);
        write_reg(CFG_HEIGHT, h);
        write_reg(CFG_GRAY_MAX, 13'(g));
    endtask

    task automatic push_byte(input logic [7:0] b, input logic fin);
        payload_item_t item;
        item.data = b;
        item.fin  = fin;
        payload_q.push_back(item);
    endtask

    // wait until every queued byte is in and every pixel is out
    task automatic settle();
        @(negedge clk);
        while (payload_q.size() != 0 || s_tvalid || expected_pixels.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    function automatic logic [7:0] pick_blank();
        int unsigned k;
        k = $urandom_range(5);
        return (k == 5) ? CHAR_SPACE : CHAR_TAB + 8'(k);
    endfunction

    function automatic logic [7:0] pick_digit();
        return CHAR_ZERO + 8'($urandom_range(9));
    endfunction

    task automatic queue_random_run(input mode_t m, input int n);
        int         cnt;
        int         nd;
        int         k;
        logic [7:0] b;
        cnt = 0;
        while (cnt < n)
        begin
            if ($urandom_range(9) == 0)
            begin
                push_byte(8'($urandom_range(255)), $urandom_range(7) == 0);
                cnt++;
            end
            else
            begin
                case (m)
                    MODE_ASCII_BIT:
                    begin
                        if ($urandom_range(3) == 0)
                            b = pick_blank();
                        else
                            b = CHAR_ZERO + 8'($urandom_range(1));
                        push_byte(b, $urandom_range(15) == 0);
                        cnt++;
                    end
                    MODE_ASCII_GRAY:
                    begin
                        nd = $urandom_range(1, 3);
                        for (k = 0; k < nd; k++)
                            push_byte(pick_digit(), k == nd - 1 && $urandom_range(7) == 0);
                        cnt += nd;
                        if ($urandom_range(9) == 0)
                        begin
                            // broken number
                            do
                                b = 8'($urandom_range(255));
                            while (is_blank(b) || (b >= CHAR_ZERO && b <= CHAR_NINE));
                            push_byte(b, $urandom_range(7) == 0);
                        end
                        else
                            push_byte(pick_blank(), $urandom_range(15) == 0);
                        cnt++;
                    end
                    default:
                    begin
                        push_byte(8'($urandom_range(255)), $urandom_range(15) == 0);
                        cnt++;
                    end
                endcase
            end
        end
    endtask

    initial
    begin
        logic [12:0] w;
        logic [12:0] h;
        logic [7:0]  g;
        int          ph;
        int          blk;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // ascii bitmap, tab and newline blanks, field extremes
        configure(MODE_ASCII_BIT, 13'd3, 13'd8191, 8'd255);
        push_byte(CHAR_ZERO, 1'b0);
        push_byte(8'h09, 1'b0);
        push_byte(CHAR_ZERO + 8'd1, 1'b0);
        push_byte(8'h0A, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b1);
        settle();

        // ascii gray: overflow past gray_max, bad char, wrap, final flush, pending kept
        write_reg(CFG_MODE, 13'(MODE_ASCII_GRAY));
        write_reg(CFG_GRAY_MAX, 13'd100);
        push_byte(CHAR_ZERO + 8'd1, 1'b0);
        push_byte(CHAR_ZERO + 8'd2, 1'b0);
        push_byte(CHAR_ZERO, 1'b0);
        push_byte(8'h0B, 1'b0);
        push_byte(CHAR_ZERO + 8'd3, 1'b0);
        push_byte(8'h78, 1'b0);
        push_byte(CHAR_ZERO + 8'd2, 1'b0);
        push_byte(CHAR_ZERO + 8'd5, 1'b0);
        push_byte(CHAR_ZERO + 8'd6, 1'b1);
        push_byte(CHAR_ZERO + 8'd7, 1'b0);
        settle();

        write_reg(CFG_MODE, 13'(MODE_RAW_GRAY));
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b0);
        settle();
        write_reg(CFG_GRAY_MAX, 13'd0);
        push_byte(8'h80, 1'b0);
        settle();
        write_reg(CFG_MODE, 13'(MODE_ASCII_GRAY));
        push_byte(8'h0C, 1'b0);
        settle();

        // packed rows with padding, out-of-range widths
        write_reg(CFG_MODE, 13'(MODE_PACKED_BIT));
        write_reg(CFG_WIDTH, 13'd5);
        push_byte(8'hA5, 1'b0);
        settle();
        write_reg(CFG_WIDTH, 13'd0);
        push_byte(8'h7F, 1'b0);
        settle();
        write_reg(CFG_WIDTH, 13'd8191);
        push_byte(8'h3C, 1'b1);
        settle();

        for (ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 70; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 70; end
                default: begin send_idle_pct = 31; recv_stall_pct = 31; end
            endcase
            for (blk = 0; blk < 4; blk++)
            begin
                case ($urandom_range(7))
                    0:       w = 13'd0;
                    1:       w = 13'd1;
                    2:       w = 13'd8191;
                    3:       w = 13'd4096;
                    4:       w = 13'd8;
                    default: w = 13'($urandom_range(1, 12));
                endcase
                // rows advance at most once per byte, so these never complete
                case ($urandom_range(2))
                    0:       h = 13'd8191;
                    1:       h = 13'd4096;
                    default: h = 13'($urandom_range(600, 4000));
                endcase
                case ($urandom_range(3))
                    0:       g = 8'd1;
                    1:       g = 8'd255;
                    default: g = 8'($urandom_range(1, 255));
                endcase
                configure(mode_t'((blk + ph) % 4), w, h, g);
                queue_random_run(mode_t'((blk + ph) % 4), RUN_LEN);
                settle();
            end
        end

        // finish the image, then bytes past the end are dropped
        send_idle_pct  = 31;
        recv_stall_pct = 31;
        configure(MODE_PACKED_BIT, 13'd3, 13'd0, 8'd255);
        push_byte(8'hF0, 1'b0);
        repeat (4) push_byte(8'($urandom_range(255)), 1'b0);
        push_byte(8'h55, 1'b1);
        settle();

        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
